// ----- hdl/sivc_pkg.sv -----
// ---------------------------------------------------------------------------
// sivc_pkg
// shared types and constants for the iv sweep analyzer
// ---------------------------------------------------------------------------
package sivc_pkg;

  localparam int VW = 24;
  localparam int PW = 48;
  localparam int DW = 64;
  localparam int QW = 64;

  localparam logic [1:0] REG_LENGTH = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_IRRAD  = 2'd2;

  localparam logic signed [VW-1:0] CURRENT_FLOOR = -24'sd10;
  localparam logic signed [VW-1:0] S24_MAX = 24'sh7FFFFF;
  localparam logic signed [VW-1:0] S24_MIN = 24'sh800000;
  localparam logic [23:0] EFF_MUL = 24'd9765625;
  localparam int EFF_SHIFT = 18;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_VOC_MUL_A, ST_VOC_MUL_B, ST_VOC_DIV, ST_VOC_FIN,
    ST_ISC_MUL_A, ST_ISC_MUL_B, ST_ISC_DIV, ST_ISC_FIN,
    ST_AREA_MUL, ST_JSC_MUL, ST_JSC_DIV, ST_JSC_FIN,
    ST_IMP_DIV, ST_IMP_FIN,
    ST_FF_MUL, ST_FF_DIV, ST_FF_FIN,
    ST_DEN_MUL, ST_EFF_MUL_HI, ST_EFF_DIV, ST_EFF_FIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic        start;
    logic [QW-1:0] num;
    logic        num_neg;
    logic [DW-1:0] den;
    logic        den_neg;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
  } div_stat_t;

  function automatic logic signed [VW-1:0] sat24(input logic signed [65:0] x);
    if (x > 66'sd8388607) return S24_MAX;
    else if (x < -66'sd8388608) return S24_MIN;
    else return x[VW-1:0];
  endfunction

endpackage

// ----- hdl/solar_iv_curve_analyzer.sv -----
// ---------------------------------------------------------------------------
// solar_iv_curve_analyzer
// iv sweep parameter extraction with one shared multiplier and divider
// ---------------------------------------------------------------------------
// A sample word that is not the last of its sweep leaves the block idle, so
// the block stays ready for the next word. The last word starts a finishing
// sequence of seven divisions, run one after another on a single radix-2
// divider with multiplies on a shared multiplier between them. Each division
// state issues its request, waits for the divider to iterate and takes the
// result, or is skipped when its divisor is zero or its result is forced.
// The input is not ready during the whole sequence. The result word then
// moves to an output register and waits there until taken; the input is
// ready again meanwhile, and a following sweep only waits at the end of its
// own finishing sequence while that earlier result is still held.
module solar_iv_curve_analyzer #(
  parameter int MAX_SAMPLES = 1048576
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [23:0] voltage,
  input  logic signed [23:0] current,
  input  logic        last_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [23:0] open_circuit_voltage,
  output logic signed [23:0] short_circuit_current,
  output logic signed [23:0] current_density,
  output logic signed [47:0] peak_power,
  output logic signed [23:0] peak_voltage,
  output logic signed [23:0] peak_current,
  output logic [15:0] fill_factor,
  output logic [15:0] efficiency,
  output logic        divide_fault
);
  import sivc_pkg::*;

  logic [13:0] cell_length, cell_width;
  logic [14:0] irradiance;
  state_t state, state_next;
  logic take, clear, done_go;
  logic signed [VW-1:0] voc_pair [4];
  logic signed [VW-1:0] isc_pair [4];
  logic signed [PW-1:0] best_power;
  logic signed [VW-1:0] best_voltage;
  div_req_t  dreq;
  div_stat_t dstat;
  logic signed [65:0] quot;
  logic [63:0] rem;

  // shared multiplier, operands chosen by state
  logic signed [32:0] ma, mb;
  logic signed [65:0] mp, mreg;

  logic signed [VW-1:0] voc, isc, jsc, imp;
  logic [15:0] ff, eff;
  logic fault;
  logic signed [VW:0] dx, dy;
  logic [27:0] lw;
  logic [43:0] den;
  logic [63:0] effq1;
  logic [63:0] r1q;
  logic skip;

  assign take  = in_valid && in_ready;
  assign in_ready = (state == ST_IDLE);
  assign done_go = (state == ST_DONE) && (!out_valid || out_ready);
  assign clear = done_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_length <= 14'd370;
      cell_width  <= 14'd330;
      irradiance  <= 15'd1000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LENGTH: cell_length <= cfg_data[13:0];
        REG_WIDTH:  cell_width  <= cfg_data[13:0];
        REG_IRRAD:  irradiance  <= cfg_data;
        default: ;
      endcase
    end
  end

  sivc_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
    .clk, .rst, .take, .clear, .voltage, .current, .last_sample,
    .voc_pair, .isc_pair, .best_power, .best_voltage
  );

  sivc_div u_div (.clk, .rst, .req(dreq), .stat(dstat), .quot, .rem);

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      ST_VOC_MUL_A: begin ma = 33'(voc_pair[3]); mb = 33'(voc_pair[0] - 25'(voc_pair[1])); end
      ST_ISC_MUL_A: begin ma = 33'(isc_pair[1]); mb = 33'(isc_pair[2] - 25'(isc_pair[3])); end
      ST_AREA_MUL:  begin ma = {19'b0, cell_length}; mb = {19'b0, cell_width}; end
      ST_JSC_MUL:   begin ma = 33'(isc); mb = 33'sd10000; end
      ST_FF_MUL:    begin ma = 33'(voc); mb = 33'(isc); end
      ST_DEN_MUL:   begin ma = {18'b0, irradiance}; mb = {5'b0, lw}; end
      ST_EFF_MUL_HI: begin ma = {3'b0, best_power[47:18]}; mb = {9'b0, EFF_MUL}; end
      default: ;
    endcase
  end
  assign mp = ma * mb;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:       if (take && last_sample) state_next = ST_VOC_MUL_A;
      ST_VOC_MUL_A:  state_next = ST_VOC_MUL_B;
      ST_VOC_MUL_B:  state_next = ST_VOC_DIV;
      ST_VOC_DIV:    if (skip || dstat.done) state_next = ST_VOC_FIN;
      ST_VOC_FIN:    state_next = ST_ISC_MUL_A;
      ST_ISC_MUL_A:  state_next = ST_ISC_MUL_B;
      ST_ISC_MUL_B:  state_next = ST_ISC_DIV;
      ST_ISC_DIV:    if (skip || dstat.done) state_next = ST_ISC_FIN;
      ST_ISC_FIN:    state_next = ST_AREA_MUL;
      ST_AREA_MUL:   state_next = ST_JSC_MUL;
      ST_JSC_MUL:    state_next = ST_JSC_DIV;
      ST_JSC_DIV:    if (skip || dstat.done) state_next = ST_JSC_FIN;
      ST_JSC_FIN:    state_next = ST_IMP_DIV;
      ST_IMP_DIV:    if (skip || dstat.done) state_next = ST_IMP_FIN;
      ST_IMP_FIN:    state_next = ST_FF_MUL;
      ST_FF_MUL:     state_next = ST_FF_DIV;
      ST_FF_DIV:     if (skip || dstat.done) state_next = ST_FF_FIN;
      ST_FF_FIN:     state_next = ST_DEN_MUL;
      ST_DEN_MUL:    state_next = ST_EFF_MUL_HI;
      ST_EFF_MUL_HI: state_next = ST_EFF_DIV;
      ST_EFF_DIV:    if (skip || dstat.done) state_next = ST_EFF_FIN;
      ST_EFF_FIN:    if (skip || dstat.done) state_next = ST_DONE;
      ST_DONE:       if (!out_valid || out_ready) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // skip a division whose divisor is zero or whose result is forced
  always_comb begin
    skip = 1'b0;
    unique case (state)
      ST_VOC_DIV: skip = (voc_pair[0] == voc_pair[1]) || (voc_pair[2] == voc_pair[3]);
      ST_ISC_DIV: skip = isc_pair[0] == isc_pair[1];
      ST_JSC_DIV: skip = lw == '0;
      ST_IMP_DIV: skip = best_voltage == '0;
      ST_FF_DIV:  skip = mreg == '0;
      ST_EFF_DIV, ST_EFF_FIN: skip = (den == '0) || (best_power <= 0);
      default:    skip = 1'b0;
    endcase
  end

  // divider request: issued on the first cycle of each divide state
  logic started;
  always_comb begin
    dreq = '0;
    dreq.start = 1'b0;
    if (!skip && !started) begin
      case (state)
        ST_VOC_DIV: begin
          dreq.start = 1'b1;
          dreq.num = 64'(mreg[65] ? -mreg : mreg); dreq.num_neg = mreg[65];
          dreq.den = 64'(dy[VW] ? -dy : dy);       dreq.den_neg = dy[VW];
        end
        ST_ISC_DIV: begin
          dreq.start = 1'b1;
          dreq.num = 64'(mreg[65] ? -mreg : mreg); dreq.num_neg = mreg[65];
          dreq.den = 64'(dx[VW] ? -dx : dx);       dreq.den_neg = dx[VW];
        end
        ST_JSC_DIV: begin
          dreq.start = 1'b1;
          dreq.num = 64'(mreg[65] ? -mreg : mreg); dreq.num_neg = mreg[65];
          dreq.den = 64'(lw);
        end
        ST_IMP_DIV: begin
          dreq.start = 1'b1;
          dreq.num = 64'(best_power[47] ? -best_power : best_power);
          dreq.num_neg = best_power[47];
          dreq.den = 64'(best_voltage[23] ? -best_voltage : best_voltage);
          dreq.den_neg = best_voltage[23];
        end
        ST_FF_DIV: begin
          dreq.start = 1'b1;
          dreq.num = {1'b0, 63'(best_power[47] ? -best_power : best_power)} << 15;
          dreq.num_neg = best_power[47];
          dreq.den = 64'(mreg[65] ? -mreg : mreg); dreq.den_neg = mreg[65];
        end
        ST_EFF_DIV: begin
          // rounded a/den, truncated quotient and remainder recovered below
          dreq.start = 1'b1;
          dreq.num = 64'(mreg); dreq.den = 64'(den);
        end
        ST_EFF_FIN: begin
          dreq.start = 1'b1;
          dreq.num = (r1q << EFF_SHIFT) + 64'(best_power[17:0]) * 64'(EFF_MUL);
          dreq.den = 64'(den) << EFF_SHIFT;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) started <= 1'b0;
    else if (state != state_next) started <= 1'b0;
    else if (dreq.start) started <= 1'b1;
  end

  logic signed [65:0] qtr;   // truncated quotient for efficiency first step
  logic [63:0] r1;
  always_comb begin
    // acc = 2a + d - 2dq has the parity of d, rem holds acc/2 rounded down
    qtr = quot;
    r1  = '0;
    if (rem >= (64'(den) >> 1)) begin
      r1 = rem - (64'(den) >> 1);
    end else begin
      qtr = quot - 66'sd1;
      r1  = rem + (64'(den) >> 1) + 64'(den[0]);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_VOC_MUL_A, ST_ISC_MUL_A, ST_JSC_MUL, ST_FF_MUL, ST_EFF_MUL_HI: mreg <= mp;
      default: ;
    endcase
    if (state == ST_VOC_MUL_A) begin
      dx <= voc_pair[0] - 25'(voc_pair[1]);
      dy <= voc_pair[2] - 25'(voc_pair[3]);
    end
    if (state == ST_ISC_MUL_A) dx <= isc_pair[0] - 25'(isc_pair[1]);
    if (state == ST_AREA_MUL) lw <= mp[27:0];
    if (state == ST_DEN_MUL) den <= mp[43:0];
    if (state == ST_IDLE && take && last_sample) fault <= 1'b0;
    case (state)
      ST_VOC_DIV:
        if (skip) begin voc <= '0; fault <= 1'b1; end
        else if (dstat.done) voc <= sat24(66'(voc_pair[1]) - quot);
      ST_ISC_DIV:
        if (skip) begin isc <= '0; fault <= 1'b1; end
        else if (dstat.done) isc <= sat24(66'(isc_pair[3]) - quot);
      ST_JSC_DIV:
        if (skip) begin jsc <= '0; fault <= 1'b1; end
        else if (dstat.done) jsc <= sat24(quot);
      ST_IMP_DIV:
        if (skip) begin imp <= '0; fault <= 1'b1; end
        else if (dstat.done) imp <= sat24(quot);
      ST_FF_DIV:
        if (skip) begin ff <= '0; fault <= 1'b1; end
        else if (dstat.done)
          ff <= quot < 0 ? 16'd0 : (quot > 66'sd65535 ? 16'hFFFF : quot[15:0]);
      ST_EFF_DIV: begin
        if (skip) begin eff <= '0; if (den == '0) fault <= 1'b1; end
        else if (dstat.done) effq1 <= 64'(qtr);
        if (dstat.done) r1q <= r1;
      end
      ST_EFF_FIN:
        if (skip) eff <= '0;
        else if (dstat.done) begin
          if (66'(effq1) + quot > 66'sd65535) eff <= 16'hFFFF;
          else eff <= 16'(effq1 + 64'(quot));
        end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (done_go) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (done_go) begin
      open_circuit_voltage  <= voc;
      short_circuit_current <= isc;
      current_density       <= jsc;
      peak_power            <= best_power;
      peak_voltage          <= best_voltage;
      peak_current          <= imp;
      fill_factor           <= ff;
      efficiency            <= eff;
      divide_fault          <= fault;
    end
  end

`ifndef SYNTHESIS
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ready) else $error("input ready while busy");
  a_done_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |=> out_valid) else $error("result not presented");
  a_last_start: assert property (@(posedge clk) disable iff (rst)
    (take && last_sample) |=> (state == ST_VOC_MUL_A)) else $error("finish not started");
`endif

endmodule

// ----- hdl/sivc_div.sv -----
// ---------------------------------------------------------------------------
// sivc_div
// shared radix-2 divider, unsigned magnitudes with round to nearest
// ---------------------------------------------------------------------------
module sivc_div (
  input  logic                 clk,
  input  logic                 rst,
  input  sivc_pkg::div_req_t   req,
  output sivc_pkg::div_stat_t  stat,
  output logic signed [65:0]   quot,
  output logic [63:0]          rem
);
  import sivc_pkg::*;

  // computes q = floor((2n + d) / 2d) on magnitudes; also exposes half the final
  // remainder, from which the truncated remainder of n / d is recovered without a second pass
  logic [6:0]   count;
  logic [65:0]  acc;
  logic [65:0]  dividend;
  logic [65:0]  divisor;
  logic [65:0]  q;
  logic         neg;
  logic [65:0]  trial;
  logic         run;

  assign trial = {acc[64:0], dividend[65]} - divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= 1'b0;
      count <= '0;
      stat  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (req.start) begin
        run      <= 1'b1;
        count    <= 7'd66;
        acc      <= '0;
        dividend <= {1'b0, req.num, 1'b0} + {2'b0, req.den};
        divisor  <= {1'b0, req.den, 1'b0};
        neg      <= req.num_neg ^ req.den_neg;
        stat.busy <= 1'b1;
      end else if (run) begin
        if (trial[65]) begin
          acc <= {acc[64:0], dividend[65]};
          q   <= {q[64:0], 1'b0};
        end else begin
          acc <= trial;
          q   <= {q[64:0], 1'b1};
        end
        dividend <= {dividend[64:0], 1'b0};
        count    <= count - 7'd1;
        if (count == 7'd1) begin
          run       <= 1'b0;
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  assign quot = neg ? -$signed(q) : $signed(q);
  // acc = 2n + d - 2d*q ; truncated remainder n - d*q = (acc - d)/2 when acc>=d
  assign rem  = acc[64:1];

endmodule

// ----- hdl/sivc_front.sv -----
// ---------------------------------------------------------------------------
// sivc_front
// per sample tracking: power maximum and bracketing pair capture
// ---------------------------------------------------------------------------
module sivc_front #(
  parameter int MAX_SAMPLES = 1048576
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           take,
  input  logic                           clear,
  input  logic signed [sivc_pkg::VW-1:0] voltage,
  input  logic signed [sivc_pkg::VW-1:0] current,
  input  logic                           last_sample,
  output logic signed [sivc_pkg::VW-1:0] voc_pair [4],
  output logic signed [sivc_pkg::VW-1:0] isc_pair [4],
  output logic signed [sivc_pkg::PW-1:0] best_power,
  output logic signed [sivc_pkg::VW-1:0] best_voltage
);
  import sivc_pkg::*;

  localparam int IW = (MAX_SAMPLES > 2) ? $clog2(MAX_SAMPLES) : 1;

  logic signed [VW-1:0] previous_voltage, previous_current;
  logic [IW-1:0]        sample_index;
  logic                 first_voltage_nonneg, first_current_nonneg;
  logic signed [PW-1:0] p;
  logic                 tv, ti;

  assign p = voltage * current;

  always_comb begin
    tv = 1'b0;
    ti = 1'b0;
    if (sample_index != '0) begin
      tv = (previous_current < 0 && current >= CURRENT_FLOOR)
        || (last_sample && first_current_nonneg && current >= 0);
      ti = (previous_voltage > 0 && voltage < 0) || (previous_voltage < 0 && voltage > 0)
        || (last_sample && first_voltage_nonneg && voltage >= 0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      previous_voltage     <= '0;
      previous_current     <= '0;
      sample_index         <= '0;
      first_voltage_nonneg <= 1'b0;
      first_current_nonneg <= 1'b0;
      best_power           <= '0;
      best_voltage         <= '0;
      for (int k = 0; k < 4; k++) begin
        voc_pair[k] <= '0;
        isc_pair[k] <= '0;
      end
    end else if (take) begin
      if (sample_index == '0) begin
        first_voltage_nonneg <= voltage >= 0;
        first_current_nonneg <= current >= 0;
      end
      if (tv) begin
        voc_pair[0] <= voltage; voc_pair[1] <= previous_voltage;
        voc_pair[2] <= current; voc_pair[3] <= previous_current;
      end
      if (ti) begin
        isc_pair[0] <= voltage; isc_pair[1] <= previous_voltage;
        isc_pair[2] <= current; isc_pair[3] <= previous_current;
      end
      if (p >= best_power) begin
        best_power   <= p;
        best_voltage <= voltage;
      end
      previous_voltage <= voltage;
      previous_current <= current;
      if (sample_index != IW'(MAX_SAMPLES - 1)) sample_index <= sample_index + 1'b1;
    end
  end

endmodule

// ----- tb/sv/solar_iv_curve_analyzer_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// solar_iv_curve_analyzer_tb
// Sweeps of iv samples, directed corner cases first and then random sweeps,
// are fed to the analyzer under random gaps and output stalls. A scoreboard
// predicts every sweep result from its own model of the block and compares
// all fields of each result word. Cell size and irradiance are changed
// between phases, including the extremes and a zero area.
// ---------------------------------------------------------------------------
module solar_iv_curve_analyzer_tb;
  import sivc_pkg::*;

  localparam longint CYCLE_LIMIT = 5000000;
  localparam int WORD_TARGET = 950;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic signed [23:0] voc, isc, jsc;
    logic signed [47:0] pmax;
    logic signed [23:0] vmp, imp;
    logic [15:0] ff, eff;
    logic fault;
  } sweep_result_t;

  class sweep_scoreboard;
    sweep_result_t pending_q[$];
    int errors = 0;
    int results_seen = 0;
    longint unsigned len_r = 370, wid_r = 330, irr_r = 1000;
    longint prev_v = 0, prev_c = 0, best_p = 0, best_v = 0;
    int idx = 0;
    bit first_v_nn = 0, first_c_nn = 0;
    longint voc_pr[4], isc_pr[4];

    function void write_reg(logic [1:0] index, logic [14:0] data);
      if (index == REG_LENGTH) len_r = data[13:0];
      else if (index == REG_WIDTH) wid_r = data[13:0];
      else if (index == REG_IRRAD) irr_r = data;
    endfunction

    function longint clip(longint x, longint lo, longint hi);
      return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function longint round_div(longint n, longint d);
      longint unsigned un, ud, q;
      un = n < 0 ? -n : n;
      ud = d < 0 ? -d : d;
      q = (2 * un + ud) / (2 * ud);
      return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function longint unsigned eff_quot(longint unsigned p, longint unsigned dn);
      longint unsigned hi, lo, a, q1, r1, x, dd, q;
      hi = p >> 18;
      lo = p & ((64'd1 << 18) - 1);
      a = hi * 64'd9765625;
      q1 = a / dn;
      r1 = a % dn;
      x = (r1 << 18) + lo * 64'd9765625;
      dd = dn << 18;
      q = q1 + (2 * x + dd) / (2 * dd);
      return q > 65535 ? 65535 : q;
    endfunction

    function void clear_sweep();
      prev_v = 0; prev_c = 0; idx = 0; first_v_nn = 0; first_c_nn = 0;
      best_p = 0; best_v = 0;
      for (int k = 0; k < 4; k++) begin
        voc_pr[k] = 0; isc_pr[k] = 0;
      end
    endfunction

    function new();
      clear_sweep();
    endfunction

    function void note_sample(logic signed [23:0] vin, logic signed [23:0] cin, bit last);
      longint v, c, p, dx, dy, lw, dn;
      longint voc, isc, jsc, imp, ff;
      longint unsigned eff;
      bit fault;
      sweep_result_t r;
      v = vin; c = cin; p = v * c;
      voc = 0; isc = 0; jsc = 0; imp = 0; ff = 0; eff = 0; fault = 0;
      if (idx == 0) begin
        first_v_nn = v >= 0;
        first_c_nn = c >= 0;
      end else begin
        if (prev_c < 0 && c >= -10) begin
          voc_pr[0] = v; voc_pr[1] = prev_v; voc_pr[2] = c; voc_pr[3] = prev_c;
        end
        if ((prev_v > 0 && v < 0) || (prev_v < 0 && v > 0)) begin
          isc_pr[0] = v; isc_pr[1] = prev_v; isc_pr[2] = c; isc_pr[3] = prev_c;
        end
        if (last && first_c_nn && c >= 0) begin
          voc_pr[0] = v; voc_pr[1] = prev_v; voc_pr[2] = c; voc_pr[3] = prev_c;
        end
        if (last && first_v_nn && v >= 0) begin
          isc_pr[0] = v; isc_pr[1] = prev_v; isc_pr[2] = c; isc_pr[3] = prev_c;
        end
      end
      if (p >= best_p) begin
        best_p = p; best_v = v;
      end
      prev_v = v; prev_c = c;
      if (idx < 1048575) idx++;
      if (!last) return;
      dx = voc_pr[0] - voc_pr[1];
      dy = voc_pr[2] - voc_pr[3];
      if (dx == 0 || dy == 0) fault = 1;
      else voc = clip(voc_pr[1] - round_div(voc_pr[3] * dx, dy), -8388608, 8388607);
      dx = isc_pr[0] - isc_pr[1];
      dy = isc_pr[2] - isc_pr[3];
      if (dx == 0) fault = 1;
      else isc = clip(isc_pr[3] - round_div(isc_pr[1] * dy, dx), -8388608, 8388607);
      lw = len_r * wid_r;
      if (lw == 0) fault = 1;
      else jsc = clip(round_div(isc * 10000, lw), -8388608, 8388607);
      if (best_v == 0) fault = 1;
      else imp = clip(round_div(best_p, best_v), -8388608, 8388607);
      if (voc * isc == 0) fault = 1;
      else ff = clip(round_div(best_p * 32768, voc * isc), 0, 65535);
      dn = irr_r * lw;
      if (dn == 0) fault = 1;
      else if (best_p > 0) eff = eff_quot(best_p, dn);
      r.voc = 24'(voc); r.isc = 24'(isc); r.jsc = 24'(jsc); r.pmax = 48'(best_p);
      r.vmp = 24'(best_v); r.imp = 24'(imp); r.ff = 16'(ff); r.eff = 16'(eff);
      r.fault = fault;
      pending_q.push_back(r);
      clear_sweep();
    endfunction

    function void check_result(sweep_result_t got);
      sweep_result_t exp;
      results_seen++;
      if (pending_q.size() == 0) begin
        $error("result word with no sweep pending");
        errors++;
        return;
      end
      exp = pending_q.pop_front();
      if (got.voc !== exp.voc) begin
        $error("open_circuit_voltage exp %0d got %0d", exp.voc, got.voc); errors++;
      end
      if (got.isc !== exp.isc) begin
        $error("short_circuit_current exp %0d got %0d", exp.isc, got.isc); errors++;
      end
      if (got.jsc !== exp.jsc) begin
        $error("current_density exp %0d got %0d", exp.jsc, got.jsc); errors++;
      end
      if (got.pmax !== exp.pmax) begin
        $error("peak_power exp %0d got %0d", exp.pmax, got.pmax); errors++;
      end
      if (got.vmp !== exp.vmp) begin
        $error("peak_voltage exp %0d got %0d", exp.vmp, got.vmp); errors++;
      end
      if (got.imp !== exp.imp) begin
        $error("peak_current exp %0d got %0d", exp.imp, got.imp); errors++;
      end
      if (got.ff !== exp.ff) begin
        $error("fill_factor exp %0d got %0d", exp.ff, got.ff); errors++;
      end
      if (got.eff !== exp.eff) begin
        $error("efficiency exp %0d got %0d", exp.eff, got.eff); errors++;
      end
      if (got.fault !== exp.fault) begin
        $error("divide_fault exp %0d got %0d", exp.fault, got.fault); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [1:0] cfg_index = '0;
  logic [14:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [23:0] voltage = '0;
  logic signed [23:0] current = '0;
  logic last_sample = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [23:0] open_circuit_voltage, short_circuit_current, current_density;
  logic signed [47:0] peak_power;
  logic signed [23:0] peak_voltage, peak_current;
  logic [15:0] fill_factor, efficiency;
  logic divide_fault;

  sweep_scoreboard sb = new();
  longint cycles = 0;
  int words_sent = 0;
  int sweeps_sent = 0;
  int cfg_writes = 0;
  bit quiet = 0;
  int stall_left = 0;

  solar_iv_curve_analyzer dut (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // output stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 0;
    end else begin
      out_ready <= 1;
      stall_left <= gap_len();
    end
  end

  always @(posedge clk) begin
    sweep_result_t got;
    if (!rst && out_valid && out_ready) begin
      got.voc = open_circuit_voltage; got.isc = short_circuit_current;
      got.jsc = current_density; got.pmax = peak_power; got.vmp = peak_voltage;
      got.imp = peak_current; got.ff = fill_factor; got.eff = efficiency;
      got.fault = divide_fault;
      sb.check_result(got);
    end
  end

  task automatic send_word(logic signed [23:0] v, logic signed [23:0] c, bit last);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    voltage <= v;
    current <= c;
    last_sample <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(v, c, last);
    words_sent++;
    if (last) sweeps_sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] index, logic [14:0] data);
    cfg_we <= 1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 0;
    sb.write_reg(index, data);
    cfg_writes++;
  endtask

  task automatic set_cell(logic [14:0] l, logic [14:0] w, logic [14:0] irr);
    drain();
    write_cfg(REG_LENGTH, l);
    write_cfg(REG_WIDTH, w);
    write_cfg(REG_IRRAD, irr);
  endtask

  function automatic logic signed [23:0] sat(longint x);
    return x > 8388607 ? 24'sh7FFFFF : (x < -8388608 ? 24'sh800000 : x[23:0]);
  endfunction

  // iv curve like sweep: voltage ramp in either direction, current falling as voltage rises
  task automatic send_curve(int n);
    longint v0, vstep, i0, istep, v, c;
    bit up;
    up = $urandom_range(0, 1);
    v0 = -longint'($urandom_range(0, 30000));
    vstep = $urandom_range(1, 20000);
    i0 = $urandom_range(0, 4000000);
    istep = $urandom_range(1, 2 * i0 / n + 1000);
    for (int k = 0; k < n; k++) begin
      int j;
      j = up ? k : n - 1 - k;
      v = v0 + vstep * j;
      c = i0 - istep * j + longint'($urandom_range(0, 40)) - 20;
      if ($urandom_range(0, 29) == 0) c = $signed(24'($urandom));
      send_word(sat(v), sat(c), k == n - 1);
    end
  endtask

  task automatic send_noise(int n);
    for (int k = 0; k < n; k++)
      send_word($signed(24'($urandom)), $signed(24'($urandom)), k == n - 1);
  endtask

  initial begin
    int n, r;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed corners at reset settings
    send_word(24'sh7FFFFF, 24'sh800000, 1);
    send_word(24'sh800000, 24'sh800000, 0);
    send_word(24'sh7FFFFF, 24'sh7FFFFF, 1);
    send_word(24'sd0, 24'sd0, 0);
    send_word(24'sd0, 24'sd0, 1);
    send_word(-24'sd100, -24'sd500, 0);
    send_word(24'sd200, -24'sd11, 0);
    send_word(24'sd300, -24'sd10, 0);
    send_word(-24'sd50, 24'sd900, 1);
    send_word(24'sd10, 24'sd1000, 0);
    send_word(24'sd20, 24'sd500, 0);
    send_word(24'sd30, 24'sd100, 1);
    send_word(-24'sd1, -24'sd1, 0);
    send_word(24'sd1, 24'sd1, 0);
    send_word(24'sh7FFFFF, 24'sh7FFFFF, 0);
    send_word(24'sh800000, 24'sh7FFFFF, 1);
    send_curve(8);

    set_cell(15'd1, 15'd1, 15'd0);
    send_word(24'sd5000, 24'sd4000, 0);
    send_word(24'sd40000, -24'sd3000, 1);
    send_curve(6);
    set_cell(15'd10000, 15'd10000, 15'd20000);
    send_curve(6);
    send_noise(3);
    set_cell(15'd0, 15'h7FFF, 15'h7FFF);
    write_cfg(REG_UNUSED, 15'h5555);
    send_curve(5);

    while (words_sent < WORD_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        quiet = $urandom_range(0, 3) == 0;
        if ($urandom_range(0, 3) == 0)
          set_cell($urandom_range(0, 1) ? 15'($urandom_range(0, 3)) : 15'($urandom),
                   15'($urandom), 15'($urandom));
        else
          set_cell(15'($urandom_range(1, 10000)), 15'($urandom_range(1, 10000)),
                   15'($urandom_range(0, 20000)));
        if ($urandom_range(0, 3) == 0) write_cfg(REG_UNUSED, 15'($urandom));
      end
      n = $urandom_range(0, 19) == 0 ? $urandom_range(40, 150) : $urandom_range(1, 14);
      if (r < 80) send_curve(n);
      else send_noise(n);
    end

    drain();
    $display("sent %0d sample words in %0d sweeps, %0d register writes", words_sent,
             sweeps_sent, cfg_writes);
    $display("checked %0d result words", sb.results_seen);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
